@@ design/iee_pkg.sv @@
// iee_pkg: types, codes and helpers for the infix expression evaluator
// used by iee_alu and infix_expression_evaluator; no dependencies
package iee_pkg;

  localparam int DEF_STACK_DEPTH = 16;
  localparam int DEF_VALUE_WIDTH = 32;

  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;

  localparam logic [2:0] OPC_ADD  = 3'd0;
  localparam logic [2:0] OPC_SUB  = 3'd1;
  localparam logic [2:0] OPC_MUL  = 3'd2;
  localparam logic [2:0] OPC_DIV  = 3'd3;
  localparam logic [2:0] OPC_OPEN = 3'd4;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_DIV0      = 3'd1;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd2;
  localparam logic [2:0] ERR_BADCHAR   = 3'd3;
  localparam logic [2:0] ERR_MALFORMED = 3'd4;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_expr;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [2:0]         error_code;
  } out_beat_t;

  typedef enum logic [1:0] {
    AOP_ADD,
    AOP_SUB,
    AOP_MUL,
    AOP_DIV
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic div0;
  } alu_sts_t;

  typedef enum logic [2:0] {
    AS_IDLE,
    AS_ADDSUB,
    AS_MUL,
    AS_NEG_A,
    AS_NEG_B,
    AS_DIV,
    AS_NEG_Q,
    AS_DONE
  } alu_st_t;

  typedef enum logic [3:0] {
    MS_IDLE,
    MS_OP_RD,
    MS_OP_CHK,
    MS_RD_B,
    MS_RD_A,
    MS_LD_A,
    MS_ALU,
    MS_FIN,
    MS_OUT
  } main_st_t;

  // high rank for * and /
  function automatic logic op_hi(input logic [2:0] op);
    return (op == OPC_MUL) || (op == OPC_DIV);
  endfunction

endpackage

@@ design/iee_alu.sv @@
// iee_alu: iterative arithmetic unit around one shared adder
// add/sub in one step, shift-add multiply, restoring divide; uses iee_pkg
module iee_alu import iee_pkg::*; #(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  alu_req_t               req,
  input  logic [VALUE_WIDTH-1:0] a,
  input  logic [VALUE_WIDTH-1:0] b,
  output alu_sts_t               sts,
  output logic [VALUE_WIDTH-1:0] res
);

  localparam int W  = VALUE_WIDTH;
  localparam int CW = $clog2(W + 1);

  alu_st_t        st_r, st_nxt;
  logic [W-1:0]   x_r, x_nxt;
  logic [W-1:0]   y_r, y_nxt;
  logic [W-1:0]   z_r, z_nxt;
  logic [W-1:0]   res_r, res_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           sign_r, sign_nxt;
  logic           sub_r, sub_nxt;
  logic           div0_r, div0_nxt;

  logic [W-1:0]   add_x, add_y;
  logic           add_sub;
  logic [W:0]     add_ye;
  logic [W:0]     sum;
  logic [W-1:0]   rem_sh;
  logic [W-1:0]   acc_new;

  assign rem_sh = {x_r[W-2:0], z_r[W-1]};

  // shared adder
  always_comb begin
    add_x   = x_r;
    add_y   = y_r;
    add_sub = 1'b0;
    case (st_r)
      AS_ADDSUB: add_sub = sub_r;
      AS_NEG_A: begin
        add_x   = '0;
        add_y   = z_r;
        add_sub = 1'b1;
      end
      AS_NEG_B: begin
        add_x   = '0;
        add_sub = 1'b1;
      end
      AS_NEG_Q: begin
        add_x   = '0;
        add_y   = z_r;
        add_sub = 1'b1;
      end
      AS_DIV: begin
        add_x   = rem_sh;
        add_sub = 1'b1;
      end
      default: ;
    endcase
    add_ye = add_sub ? ~{1'b0, add_y} : {1'b0, add_y};
    sum    = {1'b0, add_x} + add_ye + {{W{1'b0}}, add_sub};
  end

  assign acc_new = z_r[0] ? sum[W-1:0] : x_r;

  always_comb begin
    st_nxt   = st_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    res_nxt  = res_r;
    cnt_nxt  = cnt_r;
    sign_nxt = sign_r;
    sub_nxt  = sub_r;
    div0_nxt = div0_r;
    case (st_r)
      AS_IDLE: begin
        if (req.start) begin
          div0_nxt = 1'b0;
          cnt_nxt  = CW'(W);
          case (req.op)
            AOP_ADD, AOP_SUB: begin
              x_nxt   = a;
              y_nxt   = b;
              sub_nxt = (req.op == AOP_SUB);
              st_nxt  = AS_ADDSUB;
            end
            AOP_MUL: begin
              x_nxt  = '0;
              y_nxt  = a;
              z_nxt  = b;
              st_nxt = AS_MUL;
            end
            AOP_DIV: begin
              z_nxt    = a;
              y_nxt    = b;
              sign_nxt = a[W-1] ^ b[W-1];
              if (b == '0) begin
                div0_nxt = 1'b1;
                st_nxt   = AS_DONE;
              end else begin
                st_nxt = AS_NEG_A;
              end
            end
            default: st_nxt = AS_IDLE;
          endcase
        end
      end
      AS_ADDSUB: begin
        res_nxt = sum[W-1:0];
        st_nxt  = AS_DONE;
      end
      AS_MUL: begin
        x_nxt   = acc_new;
        y_nxt   = {y_r[W-2:0], 1'b0};
        z_nxt   = {1'b0, z_r[W-1:1]};
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          res_nxt = acc_new;
          st_nxt  = AS_DONE;
        end
      end
      AS_NEG_A: begin
        if (z_r[W-1]) begin
          z_nxt = sum[W-1:0];
        end
        st_nxt = AS_NEG_B;
      end
      AS_NEG_B: begin
        if (y_r[W-1]) begin
          y_nxt = sum[W-1:0];
        end
        x_nxt  = '0;
        st_nxt = AS_DIV;
      end
      AS_DIV: begin
        if (!sum[W]) begin
          x_nxt = sum[W-1:0];
          z_nxt = {z_r[W-2:0], 1'b1};
        end else begin
          x_nxt = rem_sh;
          z_nxt = {z_r[W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          st_nxt = AS_NEG_Q;
        end
      end
      AS_NEG_Q: begin
        res_nxt = sign_r ? sum[W-1:0] : z_r;
        st_nxt  = AS_DONE;
      end
      AS_DONE: st_nxt = AS_IDLE;
      default: st_nxt = AS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= AS_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    res_r  <= res_nxt;
    cnt_r  <= cnt_nxt;
    sign_r <= sign_nxt;
    sub_r  <= sub_nxt;
    div0_r <= div0_nxt;
  end

  assign sts.done = (st_r == AS_DONE);
  assign sts.div0 = div0_r;
  assign res      = res_r;

endmodule

@@ design/infix_expression_evaluator.sv @@
// infix_expression_evaluator: one character per beat, two-stack evaluation, iee_alu shared
// a digit or '(' is written in MS_IDLE; each reduction steps through MS_OP_RD, MS_OP_CHK,
//   MS_RD_B, MS_RD_A and MS_LD_A, then waits in MS_ALU until the alu is done
// throughput: one beat at a time, in_stall high until the beat is fully processed
// after its final reductions an end beat passes MS_FIN and MS_OUT and loads one result beat
// reset: synchronous active-low rst_n clears the state, stack counts, error and output valid
module infix_expression_evaluator import iee_pkg::*; #(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  localparam int W  = VALUE_WIDTH;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  main_st_t       state_r, state_nxt;
  logic [CW-1:0]  vcnt_r, vcnt_nxt;
  logic [CW-1:0]  ocnt_r, ocnt_nxt;
  logic [2:0]     err_r, err_nxt;
  logic           cls_r, cls_nxt;
  logic           fin_r, fin_nxt;
  logic           last_r, last_nxt;
  logic [2:0]     opc_r, opc_nxt;
  logic [2:0]     rop_r, rop_nxt;
  logic [W-1:0]   b_r, b_nxt;
  logic           out_valid_r;
  out_beat_t      out_data_r;

  logic [W-1:0]   vmem [STACK_DEPTH];
  logic [2:0]     omem [STACK_DEPTH];
  logic [W-1:0]   v_rd_r;
  logic [2:0]     o_rd_r;
  logic [AW-1:0]  v_raddr, v_waddr;
  logic [AW-1:0]  o_waddr;
  logic [W-1:0]   v_wdata;
  logic [2:0]     o_wdata;
  logic           v_we, o_we;

  alu_req_t       alu_req;
  alu_sts_t       alu_sts;
  logic [W-1:0]   alu_res;

  logic           in_acc;
  logic           out_load;
  logic           cur_last;
  main_st_t       post_st;
  logic [CW-1:0]  vm1, vm2, om1;
  logic           is_digit;
  logic           v_full, o_full;
  logic           red_go;
  logic signed [W-1:0]  top_val;
  logic signed [63:0]   top_wide;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != MS_IDLE);
  assign out_load = (state_r == MS_OUT) && (!out_valid_r || !out_stall);

  assign vm1    = vcnt_r - CW'(1);
  assign vm2    = vcnt_r - CW'(2);
  assign om1    = ocnt_r - CW'(1);
  assign v_full = (vcnt_r >= CW'(STACK_DEPTH));
  assign o_full = (ocnt_r >= CW'(STACK_DEPTH));
  assign is_digit = (in_data.char_code >= CH_ZERO) && (in_data.char_code <= CH_NINE);

  assign cur_last = (state_r == MS_IDLE) ? in_data.end_of_expr : last_r;
  assign post_st  = cur_last ? MS_OP_RD : MS_IDLE;

  // reduce while the top is not an open bracket and precedence allows
  assign red_go = (o_rd_r != OPC_OPEN) &&
                  (fin_r || cls_r || !(op_hi(opc_r) && !op_hi(o_rd_r)));

  always_comb begin
    state_nxt = state_r;
    vcnt_nxt  = vcnt_r;
    ocnt_nxt  = ocnt_r;
    err_nxt   = err_r;
    cls_nxt   = cls_r;
    fin_nxt   = fin_r;
    last_nxt  = last_r;
    opc_nxt   = opc_r;
    rop_nxt   = rop_r;
    b_nxt     = b_r;
    v_we      = 1'b0;
    v_waddr   = vcnt_r[AW-1:0];
    v_wdata   = W'(in_data.char_code[3:0]);
    o_we      = 1'b0;
    o_waddr   = ocnt_r[AW-1:0];
    o_wdata   = opc_r;
    v_raddr   = '0;
    alu_req.start = 1'b0;
    alu_req.op    = alu_op_t'(rop_r[1:0]);
    case (state_r)
      MS_IDLE: begin
        if (in_acc) begin
          last_nxt = in_data.end_of_expr;
          fin_nxt  = in_data.end_of_expr;
          cls_nxt  = 1'b0;
          if (err_r != ERR_NONE) begin
            state_nxt = in_data.end_of_expr ? MS_FIN : MS_IDLE;
          end else begin
            state_nxt = post_st;
            case (in_data.char_code)
              CH_OPEN: begin
                if (o_full) begin
                  err_nxt = ERR_OVERFLOW;
                end else begin
                  o_we     = 1'b1;
                  o_wdata  = OPC_OPEN;
                  ocnt_nxt = ocnt_r + CW'(1);
                end
              end
              CH_CLOSE: begin
                cls_nxt   = 1'b1;
                fin_nxt   = 1'b0;
                state_nxt = MS_OP_RD;
              end
              CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH: begin
                fin_nxt   = 1'b0;
                state_nxt = MS_OP_RD;
                case (in_data.char_code)
                  CH_PLUS:  opc_nxt = OPC_ADD;
                  CH_MINUS: opc_nxt = OPC_SUB;
                  CH_STAR:  opc_nxt = OPC_MUL;
                  default:  opc_nxt = OPC_DIV;
                endcase
              end
              default: begin
                if (!is_digit) begin
                  err_nxt = ERR_BADCHAR;
                end else if (v_full) begin
                  err_nxt = ERR_OVERFLOW;
                end else begin
                  v_we     = 1'b1;
                  vcnt_nxt = vcnt_r + CW'(1);
                end
              end
            endcase
          end
        end
      end
      MS_OP_RD: begin
        if (err_r != ERR_NONE) begin
          state_nxt = fin_r ? MS_FIN : post_st;
          fin_nxt   = 1'b1;
        end else if (ocnt_r == '0) begin
          fin_nxt = 1'b1;
          if (fin_r) begin
            state_nxt = MS_FIN;
          end else begin
            state_nxt = post_st;
            if (cls_r) begin
              err_nxt = ERR_MALFORMED;
            end else begin
              o_we     = 1'b1;
              ocnt_nxt = ocnt_r + CW'(1);
            end
          end
        end else begin
          state_nxt = MS_OP_CHK;
        end
      end
      MS_OP_CHK: begin
        if (red_go) begin
          if (vcnt_r < CW'(2)) begin
            err_nxt   = ERR_MALFORMED;
            state_nxt = MS_OP_RD;
          end else begin
            rop_nxt   = o_rd_r;
            ocnt_nxt  = om1;
            state_nxt = MS_RD_B;
          end
        end else if (fin_r) begin
          err_nxt   = ERR_MALFORMED;
          state_nxt = MS_FIN;
        end else begin
          fin_nxt   = 1'b1;
          state_nxt = post_st;
          if (cls_r) begin
            ocnt_nxt = om1;
          end else if (o_full) begin
            err_nxt = ERR_OVERFLOW;
          end else begin
            o_we     = 1'b1;
            ocnt_nxt = ocnt_r + CW'(1);
          end
        end
      end
      MS_RD_B: begin
        v_raddr   = vm1[AW-1:0];
        state_nxt = MS_RD_A;
      end
      MS_RD_A: begin
        b_nxt     = v_rd_r;
        v_raddr   = vm2[AW-1:0];
        state_nxt = MS_LD_A;
      end
      MS_LD_A: begin
        if (rop_r[2]) begin
          err_nxt   = ERR_MALFORMED;
          state_nxt = MS_OP_RD;
        end else begin
          alu_req.start = 1'b1;
          state_nxt     = MS_ALU;
        end
      end
      MS_ALU: begin
        if (alu_sts.done) begin
          state_nxt = MS_OP_RD;
          if (alu_sts.div0) begin
            err_nxt = ERR_DIV0;
          end else begin
            v_we     = 1'b1;
            v_waddr  = vm2[AW-1:0];
            v_wdata  = alu_res;
            vcnt_nxt = vm1;
          end
        end
      end
      MS_FIN: begin
        if (err_r == ERR_NONE && vcnt_r != CW'(1)) begin
          err_nxt = ERR_MALFORMED;
        end
        state_nxt = MS_OUT;
      end
      MS_OUT: begin
        if (out_load) begin
          vcnt_nxt  = '0;
          ocnt_nxt  = '0;
          err_nxt   = ERR_NONE;
          state_nxt = MS_IDLE;
        end
      end
      default: state_nxt = MS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= MS_IDLE;
      vcnt_r      <= '0;
      ocnt_r      <= '0;
      err_r       <= ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vcnt_r  <= vcnt_nxt;
      ocnt_r  <= ocnt_nxt;
      err_r   <= err_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cls_r  <= cls_nxt;
    fin_r  <= fin_nxt;
    last_r <= last_nxt;
    opc_r  <= opc_nxt;
    rop_r  <= rop_nxt;
    b_r    <= b_nxt;
  end

  // stack memories
  always_ff @(posedge clk) begin
    if (v_we) begin
      vmem[v_waddr] <= v_wdata;
    end
    v_rd_r <= vmem[v_raddr];
  end

  always_ff @(posedge clk) begin
    if (o_we) begin
      omem[o_waddr] <= o_wdata;
    end
    o_rd_r <= omem[om1[AW-1:0]];
  end

  assign top_val  = v_rd_r;
  assign top_wide = 64'(top_val);

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.error_code   <= err_r;
      out_data_r.result_value <= (err_r == ERR_NONE) ? top_wide[31:0] : 32'sd0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  iee_alu #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .a     (v_rd_r),
    .b     (b_r),
    .sts   (alu_sts),
    .res   (alu_res)
  );

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (vcnt_r <= CW'(STACK_DEPTH)) && (ocnt_r <= CW'(STACK_DEPTH)))
    else $error("stack count beyond depth");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.error_code != ERR_NONE) |-> out_data.result_value == 32'sd0)
    else $error("result not zero on error beat");

  a_alu_done: assert property (@(posedge clk) disable iff (!rst_n)
    alu_sts.done |-> state_r == MS_ALU)
    else $error("alu finished outside wait state");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (vcnt_r == '0) && (ocnt_r == '0) && (err_r == ERR_NONE) && out_valid)
    else $error("state not cleared after result beat");
`endif

endmodule

@@ dv/infix_expression_evaluator_test.sv @@
`timescale 1ns / 100ps
// infix_expression_evaluator_test: drives character beats, predicts each end-of-expression
// result with its own two-stack evaluator and checks the result beats; needs iee_pkg and the dut
module infix_expression_evaluator_test;
  import iee_pkg::*;

  localparam int ITEMS = 1350;
  localparam int TAIL = 150;
  localparam int LIMIT = 4000000;
  localparam int DEPTH = DEF_STACK_DEPTH;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_beat_t out_data;

  infix_expression_evaluator dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #6 clk = ~clk;

  in_beat_t char_beats[$];
  logic [7:0] expr_chars[$];
  out_beat_t results_due[$];

  logic [31:0] calc_vals[DEPTH];
  logic [2:0] calc_ops[DEPTH];
  int n_vals = 0;
  int n_ops = 0;
  logic [2:0] calc_err = ERR_NONE;

  int n_sent = 0;
  int n_checked = 0;
  int n_fail = 0;
  int seen_code[8];
  int send_gap = 0;
  int recv_gap = 0;
  bit send_bursty = 1'b1;
  bit recv_bursty = 1'b1;
  int cycles = 0;

  // evaluator state mirror

  function automatic void raise_error(input logic [2:0] code);
    if (calc_err == ERR_NONE) calc_err = code;
  endfunction

  function automatic bit binds_tight(input logic [2:0] op);
    return op == OPC_MUL || op == OPC_DIV;
  endfunction

  function automatic void push_val(input logic [31:0] v);
    if (n_vals >= DEPTH) begin
      raise_error(ERR_OVERFLOW);
      return;
    end
    calc_vals[n_vals] = v;
    n_vals++;
  endfunction

  function automatic void push_op(input logic [2:0] op);
    if (n_ops >= DEPTH) begin
      raise_error(ERR_OVERFLOW);
      return;
    end
    calc_ops[n_ops] = op;
    n_ops++;
  endfunction

  function automatic void reduce_top();
    logic [2:0] op;
    logic [31:0] a, b, ma, mb, q, r;
    if (n_ops == 0 || n_vals < 2) begin
      raise_error(ERR_MALFORMED);
      return;
    end
    n_ops--;
    op = calc_ops[n_ops];
    n_vals--;
    b = calc_vals[n_vals];
    n_vals--;
    a = calc_vals[n_vals];
    case (op)
      OPC_ADD: r = a + b;
      OPC_SUB: r = a - b;
      OPC_MUL: r = a * b;
      OPC_DIV: begin
        if (b == 32'd0) begin
          raise_error(ERR_DIV0);
          return;
        end
        ma = a[31] ? 32'd0 - a : a;
        mb = b[31] ? 32'd0 - b : b;
        q = ma / mb;
        r = (a[31] ^ b[31]) ? 32'd0 - q : q;
      end
      default: begin
        raise_error(ERR_MALFORMED);
        return;
      end
    endcase
    calc_vals[n_vals] = r;
    n_vals++;
  endfunction

  function automatic void take_char(input logic [7:0] c);
    logic [2:0] op;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      push_val(32'(c - CH_ZERO));
      return;
    end
    if (c == CH_OPEN) begin
      push_op(OPC_OPEN);
      return;
    end
    if (c == CH_CLOSE) begin
      while (calc_err == ERR_NONE && n_ops > 0 && calc_ops[n_ops-1] != OPC_OPEN)
        reduce_top();
      if (calc_err != ERR_NONE) return;
      if (n_ops == 0) raise_error(ERR_MALFORMED);
      else n_ops--;
      return;
    end
    case (c)
      CH_PLUS:  op = OPC_ADD;
      CH_MINUS: op = OPC_SUB;
      CH_STAR:  op = OPC_MUL;
      CH_SLASH: op = OPC_DIV;
      default: begin
        raise_error(ERR_BADCHAR);
        return;
      end
    endcase
    while (calc_err == ERR_NONE && n_ops > 0 && calc_ops[n_ops-1] != OPC_OPEN &&
           (!binds_tight(op) || binds_tight(calc_ops[n_ops-1])))
      reduce_top();
    if (calc_err == ERR_NONE) push_op(op);
  endfunction

  function automatic void evaluate_beat(input in_beat_t beat);
    out_beat_t res;
    if (calc_err == ERR_NONE) take_char(beat.char_code);
    if (!beat.end_of_expr) return;
    while (calc_err == ERR_NONE && n_ops > 0) begin
      if (calc_ops[n_ops-1] == OPC_OPEN) raise_error(ERR_MALFORMED);
      else reduce_top();
    end
    if (calc_err == ERR_NONE && n_vals != 1) raise_error(ERR_MALFORMED);
    res.result_value = (calc_err == ERR_NONE) ? calc_vals[0] : 32'd0;
    res.error_code = calc_err;
    results_due.push_back(res);
    n_vals = 0;
    n_ops = 0;
    calc_err = ERR_NONE;
  endfunction

  // stimulus builders

  task automatic add_text(input string s);
    in_beat_t b;
    for (int i = 0; i < s.len(); i++) begin
      b.char_code = s[i];
      b.end_of_expr = (i == s.len() - 1);
      char_beats.push_back(b);
    end
  endtask

  task automatic commit_expr();
    in_beat_t b;
    for (int i = 0; i < expr_chars.size(); i++) begin
      b.char_code = expr_chars[i];
      b.end_of_expr = (i == expr_chars.size() - 1);
      char_beats.push_back(b);
    end
    expr_chars.delete();
  endtask

  function automatic logic [7:0] any_op();
    case ($urandom_range(0, 3))
      0: return CH_PLUS;
      1: return CH_MINUS;
      2: return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  function automatic logic [7:0] any_digit(input int lo);
    logic [7:0] d;
    d = 8'($urandom_range(lo, 9));
    return CH_ZERO + d;
  endfunction

  // well-formed expression with random nesting
  task automatic build_expr(input int operands, input int max_nest, input int lo);
    int nest;
    nest = 0;
    for (int k = 0; k < operands; k++) begin
      if (k > 0) begin
        while (nest > 0 && $urandom_range(0, 3) == 0) begin
          expr_chars.push_back(CH_CLOSE);
          nest--;
        end
        expr_chars.push_back(any_op());
      end
      while (nest < max_nest && $urandom_range(0, 3) == 0) begin
        expr_chars.push_back(CH_OPEN);
        nest++;
      end
      expr_chars.push_back(any_digit(lo));
    end
    while (nest > 0) begin
      expr_chars.push_back(CH_CLOSE);
      nest--;
    end
  endtask

  task automatic break_expr();
    int idx;
    logic [7:0] x;
    idx = $urandom_range(0, expr_chars.size() - 1);
    case ($urandom_range(0, 2))
      0: expr_chars[idx] = 8'($urandom_range(0, 255));
      1: if (expr_chars.size() > 1) expr_chars.delete(idx);
      default: begin
        case ($urandom_range(0, 3))
          0: x = CH_OPEN;
          1: x = CH_CLOSE;
          2: x = any_digit(0);
          default: x = any_op();
        endcase
        expr_chars.insert(idx, x);
      end
    endcase
  endtask

  task automatic fill_stimulus();
    int pick, n;
    add_text("9");
    add_text("1+2*3-4/3");
    add_text("(0-7)/2");
    add_text("5/0");
    add_text("-1");
    add_text("12");
    add_text(")");
    add_text("(1");
    expr_chars.push_back(8'hFF);
    commit_expr();
    expr_chars.push_back(8'h00);
    commit_expr();
    add_text("0");
    while (char_beats.size() < ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 62) begin
        build_expr($urandom_range(1, 9), $urandom_range(0, 4), $urandom_range(0, 1));
      end else if (pick < 72) begin
        build_expr($urandom_range(1, 7), $urandom_range(0, 3), 0);
        break_expr();
      end else if (pick < 76) begin
        // long digit runs fill the value stack
        n = $urandom_range(14, 18);
        repeat (n) expr_chars.push_back(any_digit(0));
      end else if (pick < 80) begin
        // right-nested expressions with random operators fill the operator stack
        n = $urandom_range(5, 9);
        repeat (n) begin
          expr_chars.push_back(any_digit(0));
          expr_chars.push_back(any_op());
          expr_chars.push_back(CH_OPEN);
        end
        expr_chars.push_back(any_digit(1));
        repeat (n) expr_chars.push_back(CH_CLOSE);
      end else if (pick < 84) begin
        // 8^n * 2 for n of 9 to 11; n = 10 wraps to the most negative value
        n = $urandom_range(9, 11);
        expr_chars.push_back(CH_ZERO + 8'd8);
        repeat (n - 1) begin
          expr_chars.push_back(CH_STAR);
          expr_chars.push_back(CH_ZERO + 8'd8);
        end
        expr_chars.push_back(CH_STAR);
        expr_chars.push_back(CH_ZERO + 8'd2);
        expr_chars.push_back(CH_SLASH);
        if ($urandom_range(0, 1) == 0) begin
          expr_chars.push_back(CH_OPEN);
          expr_chars.push_back(CH_ZERO);
          expr_chars.push_back(CH_MINUS);
          expr_chars.push_back(CH_ZERO + 8'd1);
          expr_chars.push_back(CH_CLOSE);
        end else begin
          expr_chars.push_back(any_digit(1));
        end
      end else if (pick < 90) begin
        n = $urandom_range(1, 6);
        repeat (n) expr_chars.push_back(8'($urandom_range(0, 255)));
      end else begin
        build_expr($urandom_range(2, 5), 1, 0);
      end
      commit_expr();
    end
  endtask

  // character beats out
  always @(posedge clk) begin
    in_beat_t nxt;
    logic nxt_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if ($urandom_range(0, 299) == 0) send_bursty = !send_bursty;
      if (in_valid && !in_stall) begin
        evaluate_beat(in_data);
        n_sent++;
      end
      if (!in_valid || !in_stall) begin
        nxt = in_data;
        nxt_valid = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (char_beats.size() > 0) begin
          if (send_bursty && char_beats.size() > TAIL && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(0, 10);
          end else begin
            nxt = char_beats.pop_front();
            nxt_valid = 1'b1;
          end
        end
        in_valid <= nxt_valid;
        in_data <= nxt;
      end
    end
  end

  // result beats in
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if ($urandom_range(0, 299) == 0) recv_bursty = !recv_bursty;
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result beat: value %0d code %0d", $time,
                   out_data.result_value, out_data.error_code);
          n_fail++;
        end else begin
          want = results_due.pop_front();
          n_checked++;
          seen_code[want.error_code]++;
          if (out_data.result_value !== want.result_value) begin
            $display("%0t: result_value expected %0d got %0d", $time,
                     want.result_value, out_data.result_value);
            n_fail++;
          end
          if (out_data.error_code !== want.error_code) begin
            $display("%0t: error_code expected %0d got %0d", $time,
                     want.error_code, out_data.error_code);
            n_fail++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else if (recv_bursty && char_beats.size() > TAIL && $urandom_range(0, 9) == 0) begin
        recv_gap = $urandom_range(0, 10);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("%0t: timeout, %0d results still due", $time, results_due.size());
      $display("infix_expression_evaluator_test: FAIL");
      $finish;
    end
  end

  initial begin
    fill_stimulus();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    while (char_beats.size() > 0 || in_valid || results_due.size() > 0) @(negedge clk);
    repeat (60) @(posedge clk);
    @(negedge clk);
    $display("%0d character beats sent, %0d results checked, %0d mismatches", n_sent,
             n_checked, n_fail);
    $display("ok %0d, divide by zero %0d, overflow %0d, bad char %0d, malformed %0d",
             seen_code[ERR_NONE], seen_code[ERR_DIV0], seen_code[ERR_OVERFLOW],
             seen_code[ERR_BADCHAR], seen_code[ERR_MALFORMED]);
    if (n_fail == 0) begin
      $display("infix_expression_evaluator_test: PASS");
    end else begin
      $display("infix_expression_evaluator_test: FAIL");
    end
    $finish;
  end

endmodule
